// ===== rtl/core/clrm_pkg.sv =====
// Shared types and constants of the lock manager.
package clrm_pkg;
  localparam int unsigned Locks = 64;
  localparam int unsigned Clients = 16;
  localparam int unsigned LockW = $clog2(Locks);
  localparam int unsigned ClientW = $clog2(Clients);
  localparam int unsigned CountW = ClientW + 1;
  localparam int unsigned QAddrW = LockW + ClientW;

  typedef enum logic [1:0] {
    LK_UNSEEN = 2'd0,
    LK_FREE = 2'd1,
    LK_HELD = 2'd2,
    LK_REVOKING = 2'd3
  } lock_state_e;

  typedef enum logic [1:0] {
    RES_OK = 2'd0,
    RES_RETRY = 2'd1,
    RES_NOENT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_POP,
    ST_WRITE,
    ST_OUT
  } fsm_e;

  // Listed from the highest bits down, so status sits in the lowest bits.
  typedef struct packed {
    logic [31:0] request_count;
    logic [ClientW-1:0] revoke_client;
    logic revoke_valid;
    logic [ClientW-1:0] grant_client;
    logic grant_valid;
    logic [1:0] status;
  } result_t;
endpackage

// ===== rtl/core/cached_lock_revocation_manager_top.sv =====
// Top level of the caching lock manager with revoke and retry.
//
// Requests arrive on the s_axis channel: tdata carries the operation
// (acquire or release), the lock index and the client number. Each request
// produces exactly one result on m_axis with a status, an optional grant to
// a waiting client, an optional revoke to the owner and the running request
// count.
// With the receiver ready, a request passes through idle, table read,
// decision, write-back and output. A release that hands the lock over
// adds a queue read. An acquire on a lock that is being revoked walks its
// wait queue one entry at a time through the single read port of the
// queue memory, comparing each entry with the requesting client in a shared
// comparator, and stops at a match or at the end of the queue. The block
// takes one request at a time.
// Reset clears all lock states and the counter; owners and queue pointers
// are rewritten on the first acquire of a lock, and the queue memory needs
// no clearing since only entries already written are ever read.
// When the receiver stalls the result holds in the output register and no
// new request is accepted until it has been taken.
module cached_lock_revocation_manager_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] operation, [6:1] lock_id, [10:7] client_id, [15:11] zero
  input  logic [15:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] status, [2] grant_valid, [6:3] grant_client, [7] revoke_valid,
  // [11:8] revoke_client, [43:12] request_count, [47:44] zero
  output logic [47:0] m_axis_tdata_o
);
  localparam int unsigned CW = clrm_pkg::ClientW;
  localparam int unsigned LW = clrm_pkg::LockW;

  clrm_pkg::fsm_e state_q, state_d;

  logic [1:0]    lstate_q [clrm_pkg::Locks];
  logic [CW-1:0] owner_q  [clrm_pkg::Locks];
  logic [CW-1:0] head_q   [clrm_pkg::Locks];
  logic [clrm_pkg::CountW-1:0] count_q [clrm_pkg::Locks];

  logic          op_q;
  logic [LW-1:0] lk_q;
  logic [CW-1:0] who_q;
  logic [1:0]    cur_st_q;
  logic [CW-1:0] cur_own_q, cur_head_q;
  logic [clrm_pkg::CountW-1:0] cur_cnt_q, idx_q, idx_d;
  logic [31:0]   counter_q;
  logic          found_q, found_d;
  clrm_pkg::result_t res_q, res_d;

  logic          we;
  logic [clrm_pkg::QAddrW-1:0] waddr, raddr;
  logic [CW-1:0] wdata, rdata;

  logic [1:0]    new_st;
  logic [CW-1:0] new_own, new_head;
  logic [clrm_pkg::CountW-1:0] new_cnt;
  logic          push;

  logic s_fire;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == clrm_pkg::ST_IDLE);
  assign m_axis_tvalid_o = (state_q == clrm_pkg::ST_OUT);
  assign m_axis_tdata_o = {4'd0, res_q.request_count, res_q.revoke_client,
                           res_q.revoke_valid, res_q.grant_client,
                           res_q.grant_valid, res_q.status};

  clrm_queue_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      clrm_pkg::ST_IDLE:   if (s_fire) state_d = clrm_pkg::ST_LOOKUP;
      clrm_pkg::ST_LOOKUP: state_d = clrm_pkg::ST_DECIDE;
      clrm_pkg::ST_DECIDE: begin
        if (!op_q && cur_st_q == clrm_pkg::LK_REVOKING && cur_cnt_q != '0) begin
          state_d = clrm_pkg::ST_SCAN;
        end else if (op_q && (cur_st_q == clrm_pkg::LK_HELD ||
                     cur_st_q == clrm_pkg::LK_REVOKING) && cur_own_q == who_q &&
                     cur_cnt_q != '0) begin
          state_d = clrm_pkg::ST_POP;
        end else begin
          state_d = clrm_pkg::ST_WRITE;
        end
      end
      clrm_pkg::ST_SCAN:     state_d = clrm_pkg::ST_SCAN_CHK;
      clrm_pkg::ST_SCAN_CHK: begin
        if (found_d || idx_q + 1'b1 >= cur_cnt_q) state_d = clrm_pkg::ST_WRITE;
        else state_d = clrm_pkg::ST_SCAN;
      end
      clrm_pkg::ST_POP:   state_d = clrm_pkg::ST_WRITE;
      clrm_pkg::ST_WRITE: state_d = clrm_pkg::ST_OUT;
      clrm_pkg::ST_OUT:   if (m_axis_tready_i) state_d = clrm_pkg::ST_IDLE;
      default:            state_d = clrm_pkg::ST_IDLE;
    endcase
  end

  // Queue read address and the shared comparator.
  always_comb begin
    raddr = {lk_q, CW'(cur_head_q + idx_q[CW-1:0])};
    found_d = found_q;
    idx_d = idx_q;
    case (state_q)
      clrm_pkg::ST_DECIDE: begin
        found_d = 1'b0;
        idx_d = '0;
      end
      clrm_pkg::ST_SCAN_CHK: begin
        found_d = (rdata == who_q);
        idx_d = idx_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Write-back decision and result.
  always_comb begin
    new_st = cur_st_q;
    new_own = cur_own_q;
    new_head = cur_head_q;
    new_cnt = cur_cnt_q;
    push = 1'b0;
    res_d = res_q;
    we = 1'b0;
    waddr = {lk_q, CW'(cur_head_q + cur_cnt_q[CW-1:0])};
    wdata = who_q;
    if (state_q == clrm_pkg::ST_WRITE) begin
      res_d = '0;
      res_d.status = clrm_pkg::RES_NOENT;
      res_d.request_count = counter_q;
      if (!op_q) begin
        if (cur_st_q == clrm_pkg::LK_UNSEEN || cur_st_q == clrm_pkg::LK_FREE) begin
          new_st = clrm_pkg::LK_HELD;
          new_own = who_q;
          if (cur_st_q == clrm_pkg::LK_UNSEEN) begin
            new_head = '0;
            new_cnt = '0;
          end
          res_d.status = clrm_pkg::RES_OK;
        end else if (cur_st_q == clrm_pkg::LK_HELD) begin
          new_st = clrm_pkg::LK_REVOKING;
          push = 1'b1;
          res_d.revoke_valid = 1'b1;
          res_d.revoke_client = cur_own_q;
          res_d.status = clrm_pkg::RES_RETRY;
        end else begin
          push = !found_q;
          res_d.status = clrm_pkg::RES_RETRY;
        end
        if (push && cur_cnt_q < clrm_pkg::CountW'(clrm_pkg::Clients)) begin
          we = 1'b1;
          new_cnt = cur_cnt_q + 1'b1;
        end
      end else if ((cur_st_q == clrm_pkg::LK_HELD || cur_st_q == clrm_pkg::LK_REVOKING)
                   && cur_own_q == who_q) begin
        res_d.status = clrm_pkg::RES_OK;
        if (cur_cnt_q == '0) begin
          new_st = clrm_pkg::LK_FREE;
          new_own = '0;
          new_head = '0;
        end else begin
          new_own = rdata;
          new_head = cur_head_q + 1'b1;
          new_cnt = cur_cnt_q - 1'b1;
          res_d.grant_valid = 1'b1;
          res_d.grant_client = rdata;
          if (cur_cnt_q != clrm_pkg::CountW'(1)) begin
            new_st = clrm_pkg::LK_REVOKING;
            res_d.revoke_valid = 1'b1;
            res_d.revoke_client = rdata;
          end else begin
            new_st = clrm_pkg::LK_HELD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clrm_pkg::ST_IDLE;
      counter_q <= '0;
      found_q <= 1'b0;
      idx_q <= '0;
      for (int i = 0; i < int'(clrm_pkg::Locks); i++) begin
        lstate_q[i] <= clrm_pkg::LK_UNSEEN;
      end
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      idx_q <= idx_d;
      if (s_fire) counter_q <= counter_q + 32'd1;
      if (state_q == clrm_pkg::ST_WRITE) begin
        lstate_q[lk_q] <= new_st;
      end
    end
  end

  // Owners and queue pointers are only trusted once the lock has been seen.
  always_ff @(posedge clk_i) begin
    if (state_q == clrm_pkg::ST_WRITE) begin
      owner_q[lk_q] <= new_own;
      head_q[lk_q] <= new_head;
      count_q[lk_q] <= new_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (s_fire) begin
      op_q <= s_axis_tdata_i[0];
      lk_q <= s_axis_tdata_i[LW:1];
      who_q <= s_axis_tdata_i[LW+CW:LW+1];
    end
    if (state_q == clrm_pkg::ST_LOOKUP) begin
      cur_st_q <= lstate_q[lk_q];
      cur_own_q <= owner_q[lk_q];
      cur_head_q <= head_q[lk_q];
      cur_cnt_q <= count_q[lk_q];
    end
  end

  // The table only changes in the write-back cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == clrm_pkg::ST_WRITE |=> state_q == clrm_pkg::ST_OUT)
    else $error("write-back not followed by result");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("request accepted while result pending");
  a_counter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> counter_q == $past(counter_q) + 32'd1)
    else $error("request counter did not advance");
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res_q.grant_valid |-> res_q.status == clrm_pkg::RES_OK)
    else $error("grant without OK status");
endmodule

// ===== rtl/core/clrm_queue_ram.sv =====
// Wait queue storage: one write port and one registered read port.
module clrm_queue_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [clrm_pkg::QAddrW-1:0] waddr_i,
  input  logic [clrm_pkg::ClientW-1:0] wdata_i,
  input  logic [clrm_pkg::QAddrW-1:0] raddr_i,
  output logic [clrm_pkg::ClientW-1:0] rdata_o
);
  logic [clrm_pkg::ClientW-1:0] mem [(2**clrm_pkg::QAddrW)];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== bench/clrm_checker.sv =====
// Checker for the lock manager: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module clrm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [47:0] m_axis_tdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_seen_o
);
  clrm_pkg::lock_state_e lk_state [clrm_pkg::Locks];
  logic [clrm_pkg::ClientW-1:0] lk_owner [clrm_pkg::Locks];
  logic [clrm_pkg::ClientW-1:0] waiters  [clrm_pkg::Locks][clrm_pkg::Clients];
  logic [clrm_pkg::ClientW-1:0] w_head   [clrm_pkg::Locks];
  logic [clrm_pkg::CountW-1:0]  w_count  [clrm_pkg::Locks];
  logic [31:0]         req_total;
  clrm_pkg::result_t   exp_buf [64];
  int unsigned         exp_wr;
  int unsigned         exp_rd;

  assign pending_o = exp_wr - exp_rd;

  function automatic logic waiting(input int lk,
                                   input logic [clrm_pkg::ClientW-1:0] who);
    for (int i = 0; i < w_count[lk]; i++)
      if (waiters[lk][(w_head[lk] + i) % clrm_pkg::Clients] == who) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void enqueue(input int lk,
                                  input logic [clrm_pkg::ClientW-1:0] who);
    if (w_count[lk] < clrm_pkg::Clients) begin
      waiters[lk][(w_head[lk] + w_count[lk]) % clrm_pkg::Clients] = who;
      w_count[lk]++;
    end
  endfunction

  function automatic clrm_pkg::result_t serve_request(input logic [15:0] d);
    clrm_pkg::result_t r;
    logic op;
    int lk;
    logic [clrm_pkg::ClientW-1:0] who;
    logic [clrm_pkg::ClientW-1:0] nxt;
    op = d[0];
    lk = d[6:1];
    who = d[10:7];
    r = '0;
    r.status = clrm_pkg::RES_NOENT;
    req_total++;
    if (!op) begin
      if (lk_state[lk] == clrm_pkg::LK_UNSEEN) begin
        lk_state[lk] = clrm_pkg::LK_FREE;
        lk_owner[lk] = '0;
        w_head[lk] = '0;
        w_count[lk] = '0;
      end
      if (lk_state[lk] == clrm_pkg::LK_FREE) begin
        lk_state[lk] = clrm_pkg::LK_HELD;
        lk_owner[lk] = who;
        r.status = clrm_pkg::RES_OK;
      end else if (lk_state[lk] == clrm_pkg::LK_HELD) begin
        lk_state[lk] = clrm_pkg::LK_REVOKING;
        enqueue(lk, who);
        r.revoke_valid = 1'b1;
        r.revoke_client = lk_owner[lk];
        r.status = clrm_pkg::RES_RETRY;
      end else begin
        if (!waiting(lk, who)) enqueue(lk, who);
        r.status = clrm_pkg::RES_RETRY;
      end
    end else if ((lk_state[lk] == clrm_pkg::LK_HELD ||
                  lk_state[lk] == clrm_pkg::LK_REVOKING) &&
                 lk_owner[lk] == who) begin
      r.status = clrm_pkg::RES_OK;
      if (w_count[lk] == 0) begin
        lk_state[lk] = clrm_pkg::LK_FREE;
        lk_owner[lk] = '0;
        w_head[lk] = '0;
      end else begin
        nxt = waiters[lk][w_head[lk]];
        w_head[lk] = w_head[lk] + 1'b1;
        w_count[lk]--;
        lk_owner[lk] = nxt;
        r.grant_valid = 1'b1;
        r.grant_client = nxt;
        if (w_count[lk] != 0) begin
          lk_state[lk] = clrm_pkg::LK_REVOKING;
          r.revoke_valid = 1'b1;
          r.revoke_client = nxt;
        end else begin
          lk_state[lk] = clrm_pkg::LK_HELD;
        end
      end
    end
    r.request_count = req_total;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    clrm_pkg::result_t got;
    clrm_pkg::result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < clrm_pkg::Locks; i++) begin
        lk_state[i] = clrm_pkg::LK_UNSEEN;
        lk_owner[i] = '0;
        w_head[i] = '0;
        w_count[i] = '0;
      end
      req_total = '0;
      exp_wr = 0;
      exp_rd = 0;
      fail_count_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        exp_buf[exp_wr % 64] = serve_request(s_axis_tdata_i);
        exp_wr++;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[43:0];
        results_seen_o <= results_seen_o + 1;
        if (m_axis_tdata_i[47:44] != 0) begin
          $error("pad: expected 0, got %0h", m_axis_tdata_i[47:44]);
          fail_count_o <= fail_count_o + 1;
        end else if (exp_wr == exp_rd) begin
          $error("unexpected result %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = exp_buf[exp_rd % 64];
          exp_rd++;
          if (got != want) begin
            fail_count_o <= fail_count_o + 1;
            if (got.status != want.status)
              $error("status: expected %0d, got %0d", want.status, got.status);
            if (got.grant_valid != want.grant_valid)
              $error("grant_valid: expected %0d, got %0d", want.grant_valid,
                     got.grant_valid);
            if (got.grant_client != want.grant_client)
              $error("grant_client: expected %0d, got %0d", want.grant_client,
                     got.grant_client);
            if (got.revoke_valid != want.revoke_valid)
              $error("revoke_valid: expected %0d, got %0d", want.revoke_valid,
                     got.revoke_valid);
            if (got.revoke_client != want.revoke_client)
              $error("revoke_client: expected %0d, got %0d", want.revoke_client,
                     got.revoke_client);
            if (got.request_count != want.request_count)
              $error("request_count: expected %0d, got %0d", want.request_count,
                     got.request_count);
          end
        end
      end
    end
  end
endmodule

// ===== bench/tb_cached_lock_revocation_manager_top.sv =====
// Testbench top: drives lock requests, stalls the result side, reports the verdict.
`timescale 1ns / 100ps
module tb_cached_lock_revocation_manager_top;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;
  localparam int RandomRequests = 1730;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned sent;
  bit          quiet_phase;

  cached_lock_revocation_manager_top u_top (.*);

  clrm_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid_i,
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o),
    .fail_count_o(fail_count),
    .pending_o(pending),
    .results_seen_o(results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Gap length: mostly short, sometimes long, none at all in quiet phases.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (quiet_phase || p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Result side stalls at random for the whole run, but not in quiet phases.
  initial begin
    int g;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      g = gap_len();
      if (g == 0) begin
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // Presents one request and holds it until the block takes it.
  task automatic send_request(input logic op, input logic [5:0] lk,
                              input logic [3:0] who);
    int g;
    g = gap_len();
    if (g != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {5'b0, who, lk, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent++;
  endtask

  initial begin
    logic [5:0] lk;
    logic [3:0] who;
    int p;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    sent = 0;
    quiet_phase = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: release of an unseen lock, first acquire, owner queued on
    // its own lock, duplicate waiter, non-owner release, hand-over chains,
    // then a full queue on the highest lock.
    send_request(OP_RELEASE, 6'd0, 4'd0);
    send_request(OP_ACQUIRE, 6'd0, 4'd0);
    send_request(OP_ACQUIRE, 6'd0, 4'd0);
    send_request(OP_ACQUIRE, 6'd0, 4'd15);
    send_request(OP_ACQUIRE, 6'd0, 4'd15);
    send_request(OP_ACQUIRE, 6'd0, 4'd7);
    send_request(OP_RELEASE, 6'd0, 4'd9);
    send_request(OP_RELEASE, 6'd0, 4'd0);
    send_request(OP_RELEASE, 6'd0, 4'd0);
    send_request(OP_RELEASE, 6'd0, 4'd15);
    send_request(OP_RELEASE, 6'd0, 4'd7);
    send_request(OP_RELEASE, 6'd0, 4'd7);
    for (int c = 0; c < 16; c++) send_request(OP_ACQUIRE, 6'd63, 4'(c));
    send_request(OP_ACQUIRE, 6'd63, 4'd0);

    // Random part: most requests go to a few hot locks so queues fill and
    // drain; releases mostly come from plausible clients.
    for (int n = 0; n < RandomRequests; n++) begin
      if (n % 400 == 200) quiet_phase = 1'b1;
      if (n % 400 == 300) quiet_phase = 1'b0;
      p = $urandom_range(99);
      lk = (p < 80) ? 6'($urandom_range(3)) : 6'($urandom_range(63));
      who = (p % 5 < 3) ? 4'($urandom_range(5)) : 4'($urandom_range(15));
      send_request($urandom_range(99) < 45 ? OP_RELEASE : OP_ACQUIRE, lk, who);
    end
    s_axis_tvalid_i <= 1'b0;

    while (results_seen < sent || pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results, incl. revokes, hand-overs,",
             sent, results_seen);
    $display("full and duplicate queues and stalls on both sides.");
    if (fail_count == 0) begin
      $display("** cached_lock_revocation_manager_top: PASSED **");
    end else begin
      $display("** cached_lock_revocation_manager_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout.");
    $display("** cached_lock_revocation_manager_top: FAILED **");
    $finish;
  end
endmodule
